[rtl/ffpa_pkg.sv]
package ffpa_pkg;

    localparam int POOL_BYTES_DEF      = 4096;
    localparam int HEADER_BYTES_DEF    = 24;
    localparam int MIN_SPLIT_BYTES_DEF = 32;
    localparam int ALIGN_BYTES_DEF     = 8;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_ZERO    = 3'd1,
        ST_NOFIT   = 3'd2,
        ST_NULL    = 3'd3,
        ST_DOUBLE  = 3'd4,
        ST_INVALID = 3'd5
    } t_status;

    localparam logic [1:0] MARK_NONE  = 2'd0;
    localparam logic [1:0] MARK_ALLOC = 2'd1;
    localparam logic [1:0] MARK_FREED = 2'd2;

    typedef struct packed {
        logic        operation;
        logic [15:0] request_bytes;
        logic [11:0] data_offset;
    } t_in_item;

    typedef struct packed {
        t_status     status;
        logic [11:0] result_offset;
        logic [11:0] granted_bytes;
    } t_out_item;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE,
        S_A_RD, S_A_CHK, S_A_WG,
        S_F_RD, S_F_CHK, S_F_NCHK, S_F_WG,
        S_W_RD, S_W_P, S_W_N, S_W_M
    } t_state;

    typedef enum logic [2:0] {
        AS_CLR, AS_G, AS_N, AS_P, AS_NEXT, AS_SPLIT
    } t_addr_sel;

    typedef enum logic [2:0] {
        WR_NONE, WR_CLR, WR_SPLIT, WR_GENT, WR_N_UNLINK, WR_P_MERGE, WR_G_UNLINK
    } t_wr_sel;

    typedef struct packed {
        t_addr_sel addr_sel;
        t_wr_sel   wr_sel;
        logic      base_p;
        logic      ld_req;
        logic      ld_g_nxt;
        logic      ld_n_nxt;
        logic      ld_gent_alloc;
        logic      ld_gent_free;
        logic      ld_gent_merge;
        logic      ld_p_zero;
        logic      ld_p_n;
        logic      ld_pent;
        logic      clr_inc;
        logic      emit;
        logic      emit_alloc;
        t_status   emit_st;
    } t_cmd;

    typedef struct packed {
        logic    clr_last;
        logic    in_free;
        logic    in_req_zero;
        logic    pre_fail;
        t_status pre_st;
        logic    a_fit;
        logic    a_split;
        logic    nxt_ok;
        logic    rd_start;
        logic    rd_free;
        logic    mark_freed;
        logic    mark_bad;
        logic    n_is_g;
        logic    g_zero;
        logic    pent_free;
    } t_stat;

endpackage

[rtl/ffpa_ram.sv]
module ffpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/ffpa_ctrl.sv]
module ffpa_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    input  ffpa_pkg::t_stat i_stat,
    output ffpa_pkg::t_cmd  o_cmd,
    output logic            busy
);

    ffpa_pkg::t_state r_state, n_state;
    logic             accept;

    assign accept = start && (r_state == ffpa_pkg::S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ffpa_pkg::S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ffpa_pkg::S_CLEAR: if (i_stat.clr_last) n_state = ffpa_pkg::S_IDLE;
            ffpa_pkg::S_IDLE: begin
                if (accept) begin
                    if (!i_stat.in_free) begin
                        if (!i_stat.in_req_zero) n_state = ffpa_pkg::S_A_RD;
                    end else if (!i_stat.pre_fail) begin
                        n_state = ffpa_pkg::S_F_RD;
                    end
                end
            end
            ffpa_pkg::S_A_RD: n_state = ffpa_pkg::S_A_CHK;
            ffpa_pkg::S_A_CHK: begin
                if (i_stat.a_fit) n_state = ffpa_pkg::S_A_WG;
                else if (!i_stat.nxt_ok) n_state = ffpa_pkg::S_IDLE;
            end
            ffpa_pkg::S_A_WG: n_state = ffpa_pkg::S_IDLE;
            ffpa_pkg::S_F_RD: n_state = ffpa_pkg::S_F_CHK;
            ffpa_pkg::S_F_CHK: begin
                if (i_stat.mark_freed || i_stat.mark_bad) n_state = ffpa_pkg::S_IDLE;
                else if (i_stat.nxt_ok) n_state = ffpa_pkg::S_F_NCHK;
                else n_state = ffpa_pkg::S_F_WG;
            end
            ffpa_pkg::S_F_NCHK: n_state = ffpa_pkg::S_F_WG;
            ffpa_pkg::S_F_WG: n_state = i_stat.g_zero ? ffpa_pkg::S_IDLE : ffpa_pkg::S_W_RD;
            ffpa_pkg::S_W_RD: n_state = ffpa_pkg::S_W_P;
            ffpa_pkg::S_W_P: n_state = i_stat.nxt_ok ? ffpa_pkg::S_W_N : ffpa_pkg::S_IDLE;
            ffpa_pkg::S_W_N: begin
                if (!i_stat.rd_start) n_state = ffpa_pkg::S_IDLE;
                else if (i_stat.n_is_g) begin
                    n_state = i_stat.pent_free ? ffpa_pkg::S_W_M : ffpa_pkg::S_IDLE;
                end else n_state = ffpa_pkg::S_W_P;
            end
            ffpa_pkg::S_W_M: n_state = ffpa_pkg::S_IDLE;
            default: n_state = ffpa_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd          = '0;
        o_cmd.addr_sel = ffpa_pkg::AS_G;
        o_cmd.wr_sel   = ffpa_pkg::WR_NONE;
        o_cmd.emit_st  = ffpa_pkg::ST_OK;
        busy           = 1'b1;
        case (r_state)
            ffpa_pkg::S_CLEAR: begin
                o_cmd.addr_sel = ffpa_pkg::AS_CLR;
                o_cmd.wr_sel   = ffpa_pkg::WR_CLR;
                o_cmd.clr_inc  = 1'b1;
            end
            ffpa_pkg::S_IDLE: begin
                busy = 1'b0;
                if (accept) begin
                    o_cmd.ld_req = 1'b1;
                    if (!i_stat.in_free && i_stat.in_req_zero) begin
                        o_cmd.emit    = 1'b1;
                        o_cmd.emit_st = ffpa_pkg::ST_ZERO;
                    end else if (i_stat.in_free && i_stat.pre_fail) begin
                        o_cmd.emit    = 1'b1;
                        o_cmd.emit_st = i_stat.pre_st;
                    end
                end
            end
            ffpa_pkg::S_A_RD: o_cmd.addr_sel = ffpa_pkg::AS_G;
            ffpa_pkg::S_A_CHK: begin
                if (i_stat.a_fit) begin
                    o_cmd.ld_gent_alloc = 1'b1;
                    if (i_stat.a_split) begin
                        o_cmd.addr_sel = ffpa_pkg::AS_SPLIT;
                        o_cmd.wr_sel   = ffpa_pkg::WR_SPLIT;
                    end
                end else if (i_stat.nxt_ok) begin
                    o_cmd.addr_sel = ffpa_pkg::AS_NEXT;
                    o_cmd.ld_g_nxt = 1'b1;
                end else begin
                    o_cmd.emit    = 1'b1;
                    o_cmd.emit_st = ffpa_pkg::ST_NOFIT;
                end
            end
            ffpa_pkg::S_A_WG: begin
                o_cmd.wr_sel     = ffpa_pkg::WR_GENT;
                o_cmd.emit       = 1'b1;
                o_cmd.emit_alloc = 1'b1;
            end
            ffpa_pkg::S_F_RD: o_cmd.addr_sel = ffpa_pkg::AS_G;
            ffpa_pkg::S_F_CHK: begin
                if (i_stat.mark_freed) begin
                    o_cmd.emit    = 1'b1;
                    o_cmd.emit_st = ffpa_pkg::ST_DOUBLE;
                end else if (i_stat.mark_bad) begin
                    o_cmd.emit    = 1'b1;
                    o_cmd.emit_st = ffpa_pkg::ST_INVALID;
                end else begin
                    o_cmd.ld_gent_free = 1'b1;
                    o_cmd.ld_n_nxt     = 1'b1;
                    o_cmd.addr_sel     = ffpa_pkg::AS_NEXT;
                end
            end
            ffpa_pkg::S_F_NCHK: begin
                if (i_stat.rd_start && i_stat.rd_free) begin
                    o_cmd.ld_gent_merge = 1'b1;
                    o_cmd.addr_sel      = ffpa_pkg::AS_N;
                    o_cmd.wr_sel        = ffpa_pkg::WR_N_UNLINK;
                end
            end
            ffpa_pkg::S_F_WG: begin
                o_cmd.wr_sel    = ffpa_pkg::WR_GENT;
                o_cmd.ld_p_zero = 1'b1;
                if (i_stat.g_zero) o_cmd.emit = 1'b1;
            end
            ffpa_pkg::S_W_RD: o_cmd.addr_sel = ffpa_pkg::AS_P;
            ffpa_pkg::S_W_P: begin
                o_cmd.base_p   = 1'b1;
                o_cmd.ld_pent  = 1'b1;
                o_cmd.ld_n_nxt = 1'b1;
                o_cmd.addr_sel = ffpa_pkg::AS_NEXT;
                if (!i_stat.nxt_ok) o_cmd.emit = 1'b1;
            end
            ffpa_pkg::S_W_N: begin
                if (!i_stat.rd_start) begin
                    o_cmd.emit = 1'b1;
                end else if (i_stat.n_is_g) begin
                    if (i_stat.pent_free) begin
                        o_cmd.addr_sel = ffpa_pkg::AS_P;
                        o_cmd.wr_sel   = ffpa_pkg::WR_P_MERGE;
                    end else o_cmd.emit = 1'b1;
                end else begin
                    o_cmd.ld_p_n   = 1'b1;
                    o_cmd.addr_sel = ffpa_pkg::AS_N;
                end
            end
            ffpa_pkg::S_W_M: begin
                o_cmd.wr_sel = ffpa_pkg::WR_G_UNLINK;
                o_cmd.emit   = 1'b1;
            end
            default: o_cmd.addr_sel = ffpa_pkg::AS_G;
        endcase
    end

endmodule

[rtl/ffpa_dpath.sv]
module ffpa_dpath #(
    parameter int POOL_BYTES      = ffpa_pkg::POOL_BYTES_DEF,
    parameter int HEADER_BYTES    = ffpa_pkg::HEADER_BYTES_DEF,
    parameter int MIN_SPLIT_BYTES = ffpa_pkg::MIN_SPLIT_BYTES_DEF,
    parameter int ALIGN_BYTES     = ffpa_pkg::ALIGN_BYTES_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ffpa_pkg::t_in_item  i_item,
    input  ffpa_pkg::t_cmd      i_cmd,
    output ffpa_pkg::t_stat     o_stat,
    output ffpa_pkg::t_out_item o_result,
    output logic                o_strobe
);

    localparam int GRAN = POOL_BYTES / ALIGN_BYTES;
    localparam int GW   = $clog2(GRAN);
    localparam int ALOG = $clog2(ALIGN_BYTES);
    localparam int BW   = $clog2(POOL_BYTES) + 1;
    localparam int NW   = BW + 5;
    localparam int DW   = BW + 4;
    localparam logic [NW-1:0] POOL_N  = NW'(POOL_BYTES);
    localparam logic [NW-1:0] HDR_N   = NW'(HEADER_BYTES);
    localparam logic [NW-1:0] SPLIT_N = NW'(HEADER_BYTES + MIN_SPLIT_BYTES);
    localparam logic [NW-1:0] AMASK_N = NW'(ALIGN_BYTES - 1);
    localparam logic [NW-1:0] GRAN_N  = NW'(GRAN);
    localparam logic [BW-1:0] HDR_B   = BW'(HEADER_BYTES);
    localparam logic [BW-1:0] INIT_B  = BW'(POOL_BYTES - HEADER_BYTES);

    logic [GW-1:0] r_g, r_n, r_p, r_clr;
    logic [NW-1:0] r_need;
    logic          r_gent_start, r_gent_free, r_pent_start, r_pent_free;
    logic [BW-1:0] r_gent_bytes, r_pent_bytes;
    logic [1:0]    r_gent_mark, r_pent_mark;
    logic          r_strobe;
    ffpa_pkg::t_out_item r_result;

    logic          ram_we;
    logic [GW-1:0] ram_addr;
    logic [DW-1:0] ram_wdata, ram_rdata;

    logic          rd_start, rd_free;
    logic [BW-1:0] rd_bytes;
    logic [1:0]    rd_mark;

    logic [NW-1:0] need_a, need_b, off_n, off_h, g_full, base_n, nb, n_full, split_nb, ng_full;
    logic [GW-1:0] base, nxt, split_g;
    logic          split_size;

    function automatic logic [11:0] split_nb_off(input logic [GW-1:0] g);
        logic [NW-1:0] v;
        v = (NW'(g) << ALOG) + HDR_N;
        return v[11:0];
    endfunction

    ffpa_ram #(.WIDTH(DW), .DEPTH(GRAN)) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_addr (ram_addr),
        .i_wdata(ram_wdata),
        .o_rdata(ram_rdata)
    );

    assign rd_start = ram_rdata[DW-1];
    assign rd_bytes = ram_rdata[DW-2 -: BW];
    assign rd_free  = ram_rdata[2];
    assign rd_mark  = ram_rdata[1:0];

    // request rounding and free-pointer decode
    always_comb begin
        need_a = (NW'(i_item.request_bytes) + AMASK_N) & ~AMASK_N;
        need_b = (need_a + NW'(4) + AMASK_N) & ~AMASK_N;
        off_n  = NW'(i_item.data_offset);
        off_h  = off_n - HDR_N;
        g_full = off_h >> ALOG;
    end

    // walk to the following block of the base granule and locate the split point
    always_comb begin
        base   = i_cmd.base_p ? r_p : r_g;
        base_n = NW'(base);
        nb     = (base_n << ALOG) + HDR_N + NW'(rd_bytes);
        n_full = nb >> ALOG;
        nxt    = n_full[GW-1:0];
        split_nb   = (NW'(r_g) << ALOG) + HDR_N + r_need;
        ng_full    = split_nb >> ALOG;
        split_g    = ng_full[GW-1:0];
        split_size = NW'(rd_bytes) >= (r_need + SPLIT_N);
    end

    always_comb begin
        o_stat             = '0;
        o_stat.clr_last    = (r_clr == GW'(GRAN - 1));
        o_stat.in_free     = (i_item.operation == ffpa_pkg::OP_FREE);
        o_stat.in_req_zero = (i_item.request_bytes == '0);
        o_stat.pre_st      = ffpa_pkg::ST_INVALID;
        if (i_item.data_offset == '0) begin
            o_stat.pre_fail = 1'b1;
            o_stat.pre_st   = ffpa_pkg::ST_NULL;
        end else if (off_n < HDR_N || (off_h & AMASK_N) != '0 || g_full >= GRAN_N) begin
            o_stat.pre_fail = 1'b1;
        end
        o_stat.a_fit      = rd_start && rd_free && (NW'(rd_bytes) >= r_need);
        o_stat.a_split    = split_size && ng_full < GRAN_N && ng_full > NW'(r_g);
        o_stat.nxt_ok     = nb < POOL_N && n_full < GRAN_N && n_full > base_n;
        o_stat.rd_start   = rd_start;
        o_stat.rd_free    = rd_free;
        o_stat.mark_freed = (rd_mark == ffpa_pkg::MARK_FREED);
        o_stat.mark_bad   = (rd_mark != ffpa_pkg::MARK_ALLOC) || !rd_start;
        o_stat.n_is_g     = (r_n == r_g);
        o_stat.g_zero     = (r_g == '0);
        o_stat.pent_free  = r_pent_free;
    end

    always_comb begin
        case (i_cmd.addr_sel)
            ffpa_pkg::AS_CLR:   ram_addr = r_clr;
            ffpa_pkg::AS_G:     ram_addr = r_g;
            ffpa_pkg::AS_N:     ram_addr = r_n;
            ffpa_pkg::AS_P:     ram_addr = r_p;
            ffpa_pkg::AS_NEXT:  ram_addr = nxt;
            ffpa_pkg::AS_SPLIT: ram_addr = split_g;
            default:            ram_addr = r_g;
        endcase
    end

    always_comb begin
        ram_we    = 1'b1;
        ram_wdata = '0;
        case (i_cmd.wr_sel)
            ffpa_pkg::WR_NONE: ram_we = 1'b0;
            ffpa_pkg::WR_CLR: begin
                if (r_clr == '0) ram_wdata = {1'b1, INIT_B, 1'b1, ffpa_pkg::MARK_FREED};
            end
            ffpa_pkg::WR_SPLIT:
                ram_wdata = {1'b1, rd_bytes - r_need[BW-1:0] - HDR_B, 1'b1, ffpa_pkg::MARK_FREED};
            ffpa_pkg::WR_GENT:
                ram_wdata = {r_gent_start, r_gent_bytes, r_gent_free, r_gent_mark};
            ffpa_pkg::WR_N_UNLINK:
                ram_wdata = {1'b0, rd_bytes, rd_free, rd_mark};
            ffpa_pkg::WR_P_MERGE:
                ram_wdata = {r_pent_start, r_pent_bytes + HDR_B + r_gent_bytes,
                             r_pent_free, r_pent_mark};
            ffpa_pkg::WR_G_UNLINK:
                ram_wdata = {1'b0, r_gent_bytes, r_gent_free, r_gent_mark};
            default: ram_we = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr    <= '0;
            r_strobe <= 1'b0;
        end else begin
            if (i_cmd.clr_inc) r_clr <= r_clr + GW'(1);
            r_strobe <= i_cmd.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_req) begin
            r_need <= need_b;
            r_g    <= o_stat.in_free ? g_full[GW-1:0] : '0;
        end
        if (i_cmd.ld_g_nxt) r_g <= nxt;
        if (i_cmd.ld_n_nxt) r_n <= nxt;
        if (i_cmd.ld_gent_alloc) begin
            r_gent_start <= 1'b1;
            r_gent_bytes <= o_stat.a_split ? r_need[BW-1:0] : rd_bytes;
            r_gent_free  <= 1'b0;
            r_gent_mark  <= ffpa_pkg::MARK_ALLOC;
        end
        if (i_cmd.ld_gent_free) begin
            r_gent_start <= rd_start;
            r_gent_bytes <= rd_bytes;
            r_gent_free  <= 1'b1;
            r_gent_mark  <= ffpa_pkg::MARK_FREED;
        end
        if (i_cmd.ld_gent_merge) r_gent_bytes <= r_gent_bytes + HDR_B + rd_bytes;
        if (i_cmd.ld_p_zero) r_p <= '0;
        if (i_cmd.ld_p_n) r_p <= r_n;
        if (i_cmd.ld_pent) begin
            r_pent_start <= rd_start;
            r_pent_bytes <= rd_bytes;
            r_pent_free  <= rd_free;
            r_pent_mark  <= rd_mark;
        end
        if (i_cmd.emit) begin
            r_result.status        <= i_cmd.emit_st;
            r_result.result_offset <= i_cmd.emit_alloc ? split_nb_off(r_g) : 12'd0;
            r_result.granted_bytes <= i_cmd.emit_alloc ? r_gent_bytes[11:0] : 12'd0;
        end
    end

    assign o_result = r_result;
    assign o_strobe = r_strobe;

endmodule

[rtl/first_fit_pool_allocator.sv]
// Sequence: zero-size, null or misplaced requests are answered in the cycle after acceptance;
//   an allocate walks the blocks from the pool start, a free merges its successor, then walks to its predecessor.
// Throughput: one item at a time; the block-table memory port (one read per block
//   visited) sets how long the walk takes.
// Reset: synchronous, active low; afterwards a clearing pass over all POOL_BYTES/ALIGN_BYTES
//   granules rebuilds the block table while busy stays high. The receiver cannot stall.
module first_fit_pool_allocator #(
    parameter int POOL_BYTES      = ffpa_pkg::POOL_BYTES_DEF,
    parameter int HEADER_BYTES    = ffpa_pkg::HEADER_BYTES_DEF,
    parameter int MIN_SPLIT_BYTES = ffpa_pkg::MIN_SPLIT_BYTES_DEF,
    parameter int ALIGN_BYTES     = ffpa_pkg::ALIGN_BYTES_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    input  ffpa_pkg::t_in_item  i_item,
    output logic                busy,
    output ffpa_pkg::t_out_item o_result,
    output logic                o_strobe
);

    // command and status between the sequencer and the block-table datapath
    ffpa_pkg::t_cmd  cmd;
    ffpa_pkg::t_stat stat;

    // sequence the first-fit walk, the split, the merges and the clearing pass
    ffpa_ctrl u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .start  (start),
        .i_stat (stat),
        .o_cmd  (cmd),
        .busy   (busy)
    );

    // hold the block table, the walk pointers and the result register
    ffpa_dpath #(
        .POOL_BYTES     (POOL_BYTES),
        .HEADER_BYTES   (HEADER_BYTES),
        .MIN_SPLIT_BYTES(MIN_SPLIT_BYTES),
        .ALIGN_BYTES    (ALIGN_BYTES)
    ) u_dpath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (i_item),
        .i_cmd   (cmd),
        .o_stat  (stat),
        .o_result(o_result),
        .o_strobe(o_strobe)
    );

    // an accepted transfer either starts work or answers in the next cycle
    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy || o_strobe))
        else $error("accepted transfer produced neither work nor result");

    // failed operations report no offset and no size
    a_fail_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.status != ffpa_pkg::ST_OK) |->
        (o_result.result_offset == '0 && o_result.granted_bytes == '0))
        else $error("failed operation carries payload");

    // a result follows either an accept or a busy cycle
    a_strobe_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> ($past(start && !busy) || $past(busy)))
        else $error("result strobe without a cause");

endmodule

[sim/first_fit_pool_allocator_checker.sv]
module first_fit_pool_allocator_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic                i_busy,
    input  ffpa_pkg::t_in_item  i_item,
    input  ffpa_pkg::t_out_item i_result,
    input  logic                i_strobe,
    output int                  o_fail_count,
    output int                  o_pending,
    output int                  o_results_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int POOL   = ffpa_pkg::POOL_BYTES_DEF;
    localparam int HDR    = ffpa_pkg::HEADER_BYTES_DEF;
    localparam int SPLIT  = ffpa_pkg::MIN_SPLIT_BYTES_DEF;
    localparam int ALIGN  = ffpa_pkg::ALIGN_BYTES_DEF;
    localparam int NGRAN  = POOL / ALIGN;

    bit         live_hdr [NGRAN];
    int         data_size[NGRAN];
    bit         is_free  [NGRAN];
    logic [1:0] mark     [NGRAN];

    ffpa_pkg::t_out_item expected_results[$];

    function automatic int round_granule(int v);
        return ((v + ALIGN - 1) / ALIGN) * ALIGN;
    endfunction

    // Return the granule after g, or -1 at the end of the pool.
    function automatic int following(int g);
        int nb;
        int n;
        nb = g * ALIGN + HDR + data_size[g];
        if (nb >= POOL) return -1;
        n = nb / ALIGN;
        if (n >= NGRAN || n <= g || !live_hdr[n]) return -1;
        return n;
    endfunction

    function automatic void pool_reset();
        for (int i = 0; i < NGRAN; i++) begin
            live_hdr[i] = 0; data_size[i] = 0; is_free[i] = 0; mark[i] = ffpa_pkg::MARK_NONE;
        end
        live_hdr[0] = 1; data_size[0] = POOL - HDR; is_free[0] = 1;
        mark[0] = ffpa_pkg::MARK_FREED;
    endfunction

    function automatic ffpa_pkg::t_out_item pool_alloc(int req);
        ffpa_pkg::t_out_item r;
        int need, g, ng;
        r = '{status: ffpa_pkg::ST_NOFIT, result_offset: '0, granted_bytes: '0};
        if (req == 0) begin
            r.status = ffpa_pkg::ST_ZERO;
            return r;
        end
        need = round_granule(round_granule(req) + 4);
        g = 0;
        for (int it = 0; it < NGRAN; it++) begin
            if (live_hdr[g] && is_free[g] && data_size[g] >= need) begin
                if (data_size[g] >= need + HDR + SPLIT) begin
                    ng = (g * ALIGN + HDR + need) / ALIGN;
                    if (ng < NGRAN && ng > g) begin
                        live_hdr[ng] = 1;
                        data_size[ng] = data_size[g] - need - HDR;
                        is_free[ng] = 1;
                        mark[ng] = ffpa_pkg::MARK_FREED;
                        data_size[g] = need;
                    end
                end
                is_free[g] = 0;
                mark[g] = ffpa_pkg::MARK_ALLOC;
                r.status = ffpa_pkg::ST_OK;
                r.result_offset = 12'(g * ALIGN + HDR);
                r.granted_bytes = 12'(data_size[g]);
                return r;
            end
            g = following(g);
            if (g < 0) break;
        end
        return r;
    endfunction

    function automatic ffpa_pkg::t_out_item pool_free(int off);
        ffpa_pkg::t_out_item r;
        int g, n, p;
        bit found;
        r = '{status: ffpa_pkg::ST_OK, result_offset: '0, granted_bytes: '0};
        found = 0;
        if (off == 0) begin
            r.status = ffpa_pkg::ST_NULL;
            return r;
        end
        if (off < HDR || ((off - HDR) % ALIGN) != 0) begin
            r.status = ffpa_pkg::ST_INVALID;
            return r;
        end
        g = (off - HDR) / ALIGN;
        if (g >= NGRAN) begin
            r.status = ffpa_pkg::ST_INVALID;
            return r;
        end
        if (mark[g] == ffpa_pkg::MARK_FREED) begin
            r.status = ffpa_pkg::ST_DOUBLE;
            return r;
        end
        if (mark[g] != ffpa_pkg::MARK_ALLOC || !live_hdr[g]) begin
            r.status = ffpa_pkg::ST_INVALID;
            return r;
        end
        mark[g] = ffpa_pkg::MARK_FREED;
        is_free[g] = 1;
        n = following(g);
        if (n >= 0 && is_free[n]) begin
            data_size[g] += HDR + data_size[n];
            live_hdr[n] = 0;
        end
        p = 0;
        if (g != 0) begin
            for (int it = 0; it < NGRAN; it++) begin
                n = following(p);
                if (n < 0) break;
                if (n == g) begin
                    found = 1;
                    break;
                end
                p = n;
            end
        end
        if (found && is_free[p]) begin
            data_size[p] += HDR + data_size[g];
            live_hdr[g] = 0;
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("%0t mismatch %s: got %0d expected %0d", $time, what, got, want);
        o_fail_count++;
    endtask

    initial begin
        o_fail_count = 0;
        o_results_seen = 0;
        pool_reset();
    end

    assign o_pending = expected_results.size();

    always @(posedge i_clk) begin
        ffpa_pkg::t_out_item want;
        if (i_rst_n && i_strobe) begin
            o_results_seen++;
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected result status", int'(i_result.status), -1);
            end else begin
                want = expected_results.pop_front();
                if (i_result.status !== want.status)
                    report_mismatch("status", i_result.status, want.status);
                if (i_result.result_offset !== want.result_offset)
                    report_mismatch("result_offset", i_result.result_offset,
                                    want.result_offset);
                if (i_result.granted_bytes !== want.granted_bytes)
                    report_mismatch("granted_bytes", i_result.granted_bytes,
                                    want.granted_bytes);
            end
        end
        if (i_rst_n && i_start && !i_busy) begin
            if (i_item.operation == ffpa_pkg::OP_ALLOC)
                expected_results.push_back(pool_alloc(int'(i_item.request_bytes)));
            else
                expected_results.push_back(pool_free(int'(i_item.data_offset)));
        end
    end
endmodule

[sim/first_fit_pool_allocator_tb.sv]
module first_fit_pool_allocator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 1130;
    localparam longint CYCLE_LIMIT = 1_000_000;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                start = 1'b0;
    ffpa_pkg::t_in_item  i_item = '0;
    logic                busy;
    ffpa_pkg::t_out_item o_result;
    logic                o_strobe;

    int fail_count;
    int pending;
    int results_seen;
    longint cycle_count = 0;

    // Offsets handed out by successful allocations; feed the frees.
    logic [11:0] held_offsets[$];
    int items_sent = 0;

    always #4 i_clk = ~i_clk;

    first_fit_pool_allocator uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_item  (i_item),
        .busy    (busy),
        .o_result(o_result),
        .o_strobe(o_strobe)
    );

    first_fit_pool_allocator_checker checker_i (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start),
        .i_busy        (busy),
        .i_item        (i_item),
        .i_result      (o_result),
        .i_strobe      (o_strobe),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_results_seen(results_seen)
    );

    // Track the live offsets so that frees mostly hit real blocks.
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe && o_result.status == ffpa_pkg::ST_OK
            && o_result.result_offset != 0)
            held_offsets.push_back(o_result.result_offset);
    end

    // Watchdog: end the run if the block stops making progress.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Hold one transfer until the block accepts it, then drop start
    // unless another item follows at once.
    task automatic send_item(logic op, logic [15:0] req, logic [11:0] off, bit keep);
        start <= 1'b1;
        i_item <= '{operation: op, request_bytes: req, data_offset: off};
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        items_sent++;
        if (!keep) start <= 1'b0;
    endtask

    task automatic send_alloc(logic [15:0] req, bit keep);
        send_item(ffpa_pkg::OP_ALLOC, req, 12'($urandom), keep);
    endtask

    task automatic send_free(logic [11:0] off, bit keep);
        send_item(ffpa_pkg::OP_FREE, 16'($urandom), off, keep);
    endtask

    // Pick a free target: usually a held block, sometimes a stale, null, misplaced
    // or random offset.
    function automatic logic [11:0] pick_free_target();
        int k, idx;
        logic [11:0] off;
        k = $urandom_range(0, 99);
        if (held_offsets.size() != 0 && k < 75) begin
            idx = $urandom_range(0, held_offsets.size() - 1);
            off = held_offsets[idx];
            // Keep the entry sometimes so a later free becomes a double free.
            if ($urandom_range(0, 3) != 0) held_offsets.delete(idx);
            return off;
        end
        if (k < 85) return 12'(ffpa_pkg::HEADER_BYTES_DEF + 8 * $urandom_range(0, 508));
        if (k < 90) return 12'd0;
        return 12'($urandom);
    endfunction

    initial begin
        int burst;
        int k;
        logic [15:0] req;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: zero size, oversized, null, misplaced, failing whole-pool grab,
        // split and coalesce, stale marker double free, marker without block.
        send_alloc(16'd0, 0);
        send_alloc(16'hFFFF, 0);
        send_alloc(16'd4096, 0);
        send_free(12'd0, 0);
        send_free(12'd8, 0);
        send_free(12'd25, 0);
        send_free(12'hFFF, 0);
        send_free(12'd24, 0);
        send_alloc(16'd4068, 0);
        send_alloc(16'd1, 0);
        send_free(12'd24, 0);
        send_alloc(16'd1, 1);
        send_alloc(16'd100, 1);
        send_alloc(16'd13, 1);
        send_alloc(16'd4000, 0);
        send_free(12'd72, 0);
        send_free(12'd24, 0);
        send_free(12'd72, 0);
        send_free(12'd224, 0);
        send_free(12'd248, 0);
        send_alloc(16'd3, 0);
        send_alloc(16'd32768, 0);
        send_free(12'd4088, 0);
        held_offsets.delete();
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);

        // Random: bursts of back-to-back transfers, most of them with idle gaps between.
        while (items_sent < RANDOM_ITEMS + 23) begin
            burst = $urandom_range(1, 12);
            for (int b = 0; b < burst; b++) begin
                k = $urandom_range(0, 99);
                if (k < 50) begin
                    case ($urandom_range(0, 9))
                        0:       req = 16'($urandom);
                        1:       req = 16'($urandom_range(0, 8));
                        2:       req = 16'($urandom_range(1000, 4100));
                        default: req = 16'($urandom_range(1, 300));
                    endcase
                    send_alloc(req, b != burst - 1);
                end else begin
                    send_free(pick_free_target(), b != burst - 1);
                end
            end
            if ($urandom_range(0, 2) != 0) repeat ($urandom_range(1, 20)) @(posedge i_clk);
        end
        start <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("covered %0d transfers, %0d results checked, mixed alloc/free with",
                 items_sent, results_seen);
        $display("split, coalesce, stale-marker and misplaced-pointer cases");
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
